// ===== rtl/sdnv_encoder_core_macros.svh =====
// ----------------------------------------------------------------------------
// SDNV encoder assertion macros
// Shared property wrappers for the encoder core checks.
// ----------------------------------------------------------------------------
`ifndef SDNV_ENCODER_CORE_MACROS_SVH
`define SDNV_ENCODER_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SDNV_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sdnv encoder check failed");

// Next-cycle implication, disabled during reset.
`define SDNV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sdnv encoder check failed");

`endif

// ===== rtl/sdnv_pkg.sv =====
// ----------------------------------------------------------------------------
// SDNV encoder package
// Sizes and transfer types for the SDNV encoder core.
// ----------------------------------------------------------------------------
package sdnv_pkg;

  localparam int MAX_IN_BYTES  = 16;
  localparam int GROUP_W       = 7;
  localparam int STORE_W       = MAX_IN_BYTES * 8;
  localparam int MAX_OUT_BYTES = (STORE_W + GROUP_W - 1) / GROUP_W;
  localparam int WORK_W        = MAX_OUT_BYTES * GROUP_W;
  localparam int CNT_W         = $clog2(MAX_IN_BYTES + 1);
  localparam int LEN_W         = 5;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0]       sdnv_byte;
    logic             last_out;
    logic [LEN_W-1:0] encoded_length;
    logic             overflow;
  } out_item_t;

endpackage

// ===== rtl/sdnv_encoder_core.sv =====
// ----------------------------------------------------------------------------
// SDNV encoder core
// Packs a big-endian unsigned number into a minimal SDNV byte stream.
// ----------------------------------------------------------------------------
// Bytes arrive most significant first, one transfer per start pulse while
// busy is low. A byte without last_in is taken and busy stays low.
// A byte with last_in starts encoding: busy then stays high until the
// final encoded byte is put on out_data. One shared 7-bit
// group shifter does all the work: it first skips empty top groups (one per
// cycle) to find the encoded length, then shifts out one group per cycle.
// Each encoded byte is on out_data for one cycle with out_valid high; the
// receiver cannot stall, so it must take every transfer. All bytes of a run
// carry the total length and the overflow flag. Leading zero bytes are
// dropped; when more significant bytes arrive than the store holds, the
// oldest are lost and overflow is set. An all-zero number gives one 0x00.
module sdnv_encoder_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  sdnv_pkg::in_item_t  in_data,
  output logic               out_valid,
  output sdnv_pkg::out_item_t out_data
);
  import sdnv_pkg::*;

  `include "sdnv_encoder_core_macros.svh"

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } state_t;

  state_t              state_r;
  logic [WORK_W-1:0]   val_r;      // kept bytes, right aligned, top padded
  logic [CNT_W-1:0]    cnt_r;      // number of kept bytes
  logic                ovf_r;
  logic [LEN_W-1:0]    len_r;      // length still in the window / final length
  logic [LEN_W-1:0]    rem_r;      // groups left to emit
  logic                out_valid_r;
  out_item_t           out_data_r;

  logic                accept;
  logic                keep_byte;
  logic [GROUP_W-1:0]  top_grp;
  logic [WORK_W-1:0]   val_load;
  logic [WORK_W-1:0]   val_shift;

  assign accept    = start && (state_r == ST_IDLE);
  assign keep_byte = (cnt_r != '0) || (in_data.data_byte != 8'h00);
  assign top_grp   = val_r[WORK_W-1 -: GROUP_W];
  // Loading drops whatever falls off the top of the store.
  assign val_load  = WORK_W'({val_r[STORE_W-9:0], in_data.data_byte});
  assign val_shift = {val_r[WORK_W-GROUP_W-1:0], {GROUP_W{1'b0}}};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      val_r       <= '0;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      len_r       <= '0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            if (keep_byte) begin
              val_r <= val_load;
              if (cnt_r == CNT_W'(MAX_IN_BYTES)) begin
                ovf_r <= 1'b1;
              end else begin
                cnt_r <= cnt_r + 1'b1;
              end
            end
            if (in_data.last_in) begin
              len_r   <= LEN_W'(MAX_OUT_BYTES);
              state_r <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          // Skip empty top groups, always keeping at least one.
          if ((top_grp == '0) && (len_r != LEN_W'(1))) begin
            val_r <= val_shift;
            len_r <= len_r - 1'b1;
          end else begin
            rem_r   <= len_r;
            state_r <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          out_valid_r                   <= 1'b1;
          out_data_r.sdnv_byte          <= {(rem_r != LEN_W'(1)), top_grp};
          out_data_r.last_out           <= (rem_r == LEN_W'(1));
          out_data_r.encoded_length     <= len_r;
          out_data_r.overflow           <= ovf_r;
          rem_r                         <= rem_r - 1'b1;
          if (rem_r == LEN_W'(1)) begin
            // End of run: clear the store and go back to idle.
            val_r   <= '0;
            cnt_r   <= '0;
            ovf_r   <= 1'b0;
            state_r <= ST_IDLE;
          end else begin
            val_r   <= val_shift;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A non-final byte means more of the run is still to come.
  `SDNV_ASSERT_IMPL(a_mid_busy, clk, rst_n, out_valid_r && !out_data_r.last_out, busy)
  // The final byte closes the run.
  `SDNV_ASSERT_NEXT(a_last_gap, clk, rst_n, out_valid_r && out_data_r.last_out, !out_valid_r)
  // Nothing leaves while the length is still being found.
  `SDNV_ASSERT_IMPL(a_scan_quiet, clk, rst_n, state_r == ST_SCAN, !out_valid_r)
  // Length of every emitted byte is in range.
  `SDNV_ASSERT_IMPL(a_len_range, clk, rst_n, out_valid_r, (out_data_r.encoded_length != '0) && (out_data_r.encoded_length <= LEN_W'(MAX_OUT_BYTES)))
  // Emit phase always has a group left.
  `SDNV_ASSERT_IMPL(a_emit_rem, clk, rst_n, state_r == ST_EMIT, rem_r != '0)

endmodule

// ===== tb/sdnv_encoder_checker.sv =====
// ----------------------------------------------------------------------------
// SDNV encoder checker
// Watches the input and result channels of the encoder core, builds the
// expected SDNV byte stream for every number and compares each result
// transfer against it field by field.
// ----------------------------------------------------------------------------
module sdnv_encoder_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                busy,
  input  sdnv_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  sdnv_pkg::out_item_t out_data,
  output int                  fail_count,
  output int                  pending,
  output int                  bytes_checked,
  output int                  numbers_seen,
  output int                  overflow_numbers
);
  timeunit 1ns;
  timeprecision 1ps;

  import sdnv_pkg::*;

  // Significant bytes kept so far, least significant byte at the bottom.
  logic [STORE_W-1:0] number_bits = '0;
  int                 kept_bytes  = 0;
  logic               bytes_lost  = 1'b0;
  out_item_t          sdnv_queue[$];
  int                 errors      = 0;
  int                 checked     = 0;
  int                 numbers     = 0;
  int                 overflows   = 0;

  // Queue the minimal SDNV of the kept number, most significant group first.
  task automatic push_encoding();
    logic [WORK_W-1:0] wide;
    int                top_bits;
    int                groups;
    int                g;
    out_item_t         item;
    wide     = WORK_W'(number_bits);
    top_bits = 0;
    for (int k = 0; k < STORE_W; k++)
      if (number_bits[k]) top_bits = k + 1;
    groups = (top_bits + GROUP_W - 1) / GROUP_W;
    if (groups == 0) groups = 1;
    for (int r = 0; r < groups; r++) begin
      g                   = groups - 1 - r;
      item.sdnv_byte      = {g != 0, wide[g*GROUP_W +: GROUP_W]};
      item.last_out       = (g == 0);
      item.encoded_length = LEN_W'(groups);
      item.overflow       = bytes_lost;
      sdnv_queue.push_back(item);
    end
  endtask

  task automatic compare_transfer();
    out_item_t want;
    if (sdnv_queue.size() == 0) begin
      $error("unexpected transfer: sdnv_byte %02h with nothing pending", out_data.sdnv_byte);
      errors++;
    end else begin
      want = sdnv_queue.pop_front();
      checked++;
      if (out_data.sdnv_byte !== want.sdnv_byte) begin
        $error("sdnv_byte: expected %02h, got %02h", want.sdnv_byte, out_data.sdnv_byte);
        errors++;
      end
      if (out_data.last_out !== want.last_out) begin
        $error("last_out: expected %0b, got %0b", want.last_out, out_data.last_out);
        errors++;
      end
      if (out_data.encoded_length !== want.encoded_length) begin
        $error("encoded_length: expected %0d, got %0d", want.encoded_length,
               out_data.encoded_length);
        errors++;
      end
      if (out_data.overflow !== want.overflow) begin
        $error("overflow: expected %0b, got %0b", want.overflow, out_data.overflow);
        errors++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      number_bits = '0;
      kept_bytes  = 0;
      bytes_lost  = 1'b0;
      sdnv_queue.delete();
    end else begin
      if (start && !busy) begin
        // Leading zero bytes are dropped; a full store loses its top byte.
        if (kept_bytes != 0 || in_data.data_byte != 8'h00) begin
          if (kept_bytes == MAX_IN_BYTES) bytes_lost = 1'b1;
          else kept_bytes++;
          number_bits = {number_bits[STORE_W-9:0], in_data.data_byte};
        end
        if (in_data.last_in) begin
          push_encoding();
          numbers++;
          if (bytes_lost) overflows++;
          number_bits = '0;
          kept_bytes  = 0;
          bytes_lost  = 1'b0;
        end
      end
      if (out_valid) compare_transfer();
    end
    fail_count       <= errors;
    pending          <= sdnv_queue.size();
    bytes_checked    <= checked;
    numbers_seen     <= numbers;
    overflow_numbers <= overflows;
  end

endmodule

// ===== tb/sdnv_encoder_core_tb.sv =====
// ----------------------------------------------------------------------------
// SDNV encoder core testbench
// Feeds big-endian numbers byte by byte into the encoder core: a short
// directed set (zero value, leading zeros, group boundaries, full store and
// store overflow), then random numbers of random length under several
// sender idle levels. A separate checker predicts and compares every
// encoded byte; this top only drives stimulus and reports the verdict.
// ----------------------------------------------------------------------------
module sdnv_encoder_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sdnv_pkg::*;

  logic      clk;
  logic      rst_n   = 1'b0;
  logic      start   = 1'b0;
  in_item_t  in_data = '0;
  logic      busy;
  logic      out_valid;
  out_item_t out_data;

  // Checker outputs.
  int fail_count;
  int pending;
  int bytes_checked;
  int numbers_seen;
  int overflow_numbers;

  // Sender idle level in percent of cycles; set per phase.
  int idle_pct   = 0;
  int bytes_sent = 0;

  // Random phases: no idling, heavy idling, none again (the receiver stall
  // phase has no meaning here since results cannot be held off), light idling.
  int idle_plan[4] = '{0, 83, 0, 15};

  sdnv_encoder_core uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  sdnv_encoder_checker sdnv_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_data        (out_data),
    .fail_count      (fail_count),
    .pending         (pending),
    .bytes_checked   (bytes_checked),
    .numbers_seen    (numbers_seen),
    .overflow_numbers(overflow_numbers)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // One byte transfer. Idle cycles come first, one coin toss per cycle, with
  // junk on in_data so a low start is seen to be ignored. Then start is held
  // high until an edge where busy is low; busy is sampled as it was before
  // the edge, which is exactly when the core took the transfer.
  task automatic send_byte(input logic [7:0] value, input logic is_last);
    while ($urandom_range(99) < idle_pct) begin
      start   <= 1'b0;
      in_data <= '{data_byte: 8'($urandom), last_in: 1'($urandom)};
      @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= '{data_byte: value, last_in: is_last};
    @(posedge clk);
    while (busy) @(posedge clk);
    bytes_sent++;
  endtask

  // Hold the sender off until every queued SDNV byte has come out. The
  // checker updates pending after each edge, so look only from the next one.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    int         lead;
    int         body;
    int         phase_start;
    logic [7:0] value;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, back to back.
    idle_pct = 0;
    // zero value: one 0x00 byte
    send_byte(8'h00, 1'b1);
    // leading zeros dropped, largest single-group value
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b1);
    // smallest two-group value
    send_byte(8'h80, 1'b1);
    // all-zero number spread over several bytes
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b1);
    // 17 significant bytes: the top 0x01 falls out of the store, overflow
    // is flagged and the remaining all-ones number takes the most groups
    send_byte(8'h01, 1'b0);
    for (int i = 0; i < MAX_IN_BYTES; i++) send_byte(8'hFF, i == MAX_IN_BYTES - 1);
    drain();

    // Random part: numbers of random length, mostly short, some long enough
    // to fill or overflow the store, some with leading zero bytes.
    foreach (idle_plan[p]) begin
      idle_pct    = idle_plan[p];
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < 30) begin
        if ($urandom_range(9) == 0) body = $urandom_range(MAX_IN_BYTES - 1, MAX_IN_BYTES + 4);
        else body = $urandom_range(0, 8);
        lead = ($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0;
        if (lead + body == 0) body = 1;
        for (int i = 0; i < lead + body; i++) begin
          if (i < lead) value = 8'h00;
          else begin
            // bias toward group-boundary patterns
            case ($urandom_range(9))
              0:       value = 8'h00;
              1:       value = 8'hFF;
              2:       value = 8'h80;
              3:       value = 8'h7F;
              4:       value = 8'h01;
              default: value = 8'($urandom);
            endcase
          end
          send_byte(value, i == lead + body - 1);
        end
      end
      // sender pauses until the core has emitted everything
      drain();
    end

    // Everything is out; watch a full encode time more for stray transfers.
    repeat (MAX_OUT_BYTES + 5) @(posedge clk);
    #1;

    $display("Encoded %0d numbers from %0d input bytes, %0d of them past the store size.",
             numbers_seen, bytes_sent, overflow_numbers);
    $display("Checked %0d SDNV bytes at sender idle levels of 0, 83 and 15 percent.",
             bytes_checked);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Run limit, far above the slowest correct run.
  initial begin
    #2ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
